@@ rtl/core/rvalu_pkg.sv @@
// Package: operation codes and shared constants for the RV32IM ALU.
`timescale 1ns / 1ps
`default_nettype none
package rvalu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned OP_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_SLL    = 5'd2,
    OP_SRL    = 5'd3,
    OP_SRA    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_AND    = 5'd7,
    OP_SLT    = 5'd8,
    OP_SLTU   = 5'd9,
    OP_MUL    = 5'd10,
    OP_MULH   = 5'd11,
    OP_MULHSU = 5'd12,
    OP_MULHU  = 5'd13,
    OP_DIV    = 5'd14,
    OP_DIVU   = 5'd15,
    OP_REM    = 5'd16,
    OP_REMU   = 5'd17
  } op_e;

  // Divider control that rides along the divide pipeline.
  typedef struct packed {
    logic want_rem;
    logic neg_q;
    logic neg_r;
    logic special;
    logic [XLEN-1:0] special_val;
  } div_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/rvalu_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
`timescale 1ns / 1ps
`default_nettype none
module rvalu_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [31:0]            dividend_i,
  input  wire logic [31:0]            divisor_i,
  input  wire rvalu_pkg::div_ctl_t    ctl_i,
  output logic                        valid_o,
  output logic [31:0]                 result_o
);
  import rvalu_pkg::*;

  localparam int unsigned NSTG = XLEN;

  logic [NSTG:1]          vld_q;
  logic [XLEN-1:0]        quo_q [1:NSTG];
  logic [XLEN-1:0]        rem_q [1:NSTG];
  logic [XLEN-1:0]        dvs_q [1:NSTG];
  div_ctl_t               ctl_q [1:NSTG];

  // Each stage shifts one dividend bit into the partial remainder and
  // subtracts when the divisor fits.
  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic            v_in;
    logic [XLEN-1:0] q_in;
    logic [XLEN-1:0] r_in;
    logic [XLEN-1:0] d_in;
    div_ctl_t        c_in;
    logic [XLEN:0]   part_d;
    logic [XLEN:0]   diff_d;
    logic [XLEN-1:0] rem_d;
    logic [XLEN-1:0] quo_d;
    if (s == 0) begin : g_head
      assign v_in = valid_i;
      assign q_in = dividend_i;
      assign r_in = '0;
      assign d_in = divisor_i;
      assign c_in = ctl_i;
    end else begin : g_body
      assign v_in = vld_q[s];
      assign q_in = quo_q[s];
      assign r_in = rem_q[s];
      assign d_in = dvs_q[s];
      assign c_in = ctl_q[s];
    end
    always_comb begin
      part_d = {r_in, q_in[XLEN-1]};
      diff_d = part_d - {1'b0, d_in};
      if (!diff_d[XLEN]) begin
        rem_d = diff_d[XLEN-1:0];
        quo_d = {q_in[XLEN-2:0], 1'b1};
      end else begin
        rem_d = part_d[XLEN-1:0];
        quo_d = {q_in[XLEN-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      quo_q[s+1] <= quo_d;
      rem_q[s+1] <= rem_d;
      dvs_q[s+1] <= d_in;
      ctl_q[s+1] <= c_in;
    end
  end

  logic [XLEN-1:0] q_fix;
  logic [XLEN-1:0] r_fix;
  always_comb begin
    q_fix = ctl_q[NSTG].neg_q ? (XLEN'(0) - quo_q[NSTG]) : quo_q[NSTG];
    r_fix = ctl_q[NSTG].neg_r ? (XLEN'(0) - rem_q[NSTG]) : rem_q[NSTG];
    if (ctl_q[NSTG].special) begin
      result_o = ctl_q[NSTG].special_val;
    end else if (ctl_q[NSTG].want_rem) begin
      result_o = r_fix;
    end else begin
      result_o = q_fix;
    end
  end
  assign valid_o = vld_q[NSTG];

endmodule
`default_nettype wire

@@ rtl/core/rv32im_alu_core.sv @@
// Top level: pipelined RV32IM integer ALU with multiply and divide.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Drive op_a_i, op_b_i and req_type_i with start_i high; the word is taken
//   on any rising edge where start_i is high and busy_o is low. busy_o is
//   tied low: the pipeline takes one word every cycle.
//   Every operation has the same latency so results leave in issue order:
//   one operand register, 32 divider stages, then one output register;
//   done_o and alu_result_o are both driven from that output register.
//   done_o is high for exactly one cycle with alu_result_o; the receiver
//   cannot stall, and nothing ever needs to wait on it.
//   Throughput is one word per cycle; the depth is set by the divider, which
//   resolves one quotient bit per stage. Non-divide results travel through a
//   matching delay line; the 32x32 multiply is split into four 16x16 partial
//   products registered before they are summed.
//   Unused codes return zero. Divide by zero and signed overflow follow
//   the RISC-V M rules.
//   Reset clears all valid bits; payload registers are not reset.
module rv32im_alu_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] op_a_i,
  input  wire logic [31:0] op_b_i,
  input  wire logic [4:0]  req_type_i,
  output logic             done_o,
  output logic [31:0]      alu_result_o
);
  import rvalu_pkg::*;

  localparam int unsigned DLY = XLEN;  // matches divider stage count

  // Result source carried down the delay line.
  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_DIV    = 2'd2;

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i & ~busy_o;

  // Stage 0: capture operands.
  logic            v0_q;
  logic [31:0]     a0_q, b0_q;
  logic [OP_W-1:0] op0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end
  always_ff @(posedge clk_i) begin
    a0_q  <= op_a_i;
    b0_q  <= op_b_i;
    op0_q <= req_type_i;
  end

  // Simple ops, computed from the stage 0 registers.
  logic [4:0]  sh;
  logic [31:0] simple_d;
  logic        is_mul, is_div;
  always_comb begin
    sh       = b0_q[4:0];
    simple_d = '0;
    is_mul   = 1'b0;
    is_div   = 1'b0;
    case (op0_q)
      OP_ADD:  simple_d = a0_q + b0_q;
      OP_SUB:  simple_d = a0_q - b0_q;
      OP_SLL:  simple_d = a0_q << sh;
      OP_SRL:  simple_d = a0_q >> sh;
      OP_SRA:  simple_d = 32'($signed(a0_q) >>> sh);
      OP_XOR:  simple_d = a0_q ^ b0_q;
      OP_OR:   simple_d = a0_q | b0_q;
      OP_AND:  simple_d = a0_q & b0_q;
      OP_SLT:  simple_d = {31'd0, $signed(a0_q) < $signed(b0_q)};
      OP_SLTU: simple_d = {31'd0, a0_q < b0_q};
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: is_mul = 1'b1;
      OP_DIV, OP_DIVU, OP_REM, OP_REMU:     is_div = 1'b1;
      default: simple_d = '0;
    endcase
  end

  // Multiply: stage 1 holds 16x16 partial products and sign corrections.
  logic [31:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q, corr_q;
  logic        mul_lo_q;
  logic [31:0] corr_d;
  always_comb begin
    corr_d = '0;
    if ((op0_q == OP_MULH || op0_q == OP_MULHSU) && a0_q[31]) corr_d = corr_d + b0_q;
    if (op0_q == OP_MULH && b0_q[31]) corr_d = corr_d + a0_q;
  end
  always_ff @(posedge clk_i) begin
    pp_ll_q  <= {16'd0, a0_q[15:0]}  * {16'd0, b0_q[15:0]};
    pp_lh_q  <= {16'd0, a0_q[15:0]}  * {16'd0, b0_q[31:16]};
    pp_hl_q  <= {16'd0, a0_q[31:16]} * {16'd0, b0_q[15:0]};
    pp_hh_q  <= {16'd0, a0_q[31:16]} * {16'd0, b0_q[31:16]};
    corr_q   <= corr_d;
    mul_lo_q <= (op0_q == OP_MUL);
  end
  // Stage 2: sum partials.
  logic [63:0] prod_q;
  logic [31:0] corr2_q;
  logic        mul_lo2_q;
  always_ff @(posedge clk_i) begin
    prod_q    <= {pp_hh_q, pp_ll_q} + ({32'd0, pp_lh_q} << 16) + ({32'd0, pp_hl_q} << 16);
    corr2_q   <= corr_q;
    mul_lo2_q <= mul_lo_q;
  end
  logic [31:0] mul_res;
  assign mul_res = mul_lo2_q ? prod_q[31:0] : (prod_q[63:32] - corr2_q);

  // Divider setup from stage 0.
  logic        d_sgn, d_rem;
  logic [31:0] ua, ub;
  div_ctl_t    dctl;
  always_comb begin
    d_sgn = (op0_q == OP_DIV) || (op0_q == OP_REM);
    d_rem = (op0_q == OP_REM) || (op0_q == OP_REMU);
    ua    = (d_sgn && a0_q[31]) ? (32'd0 - a0_q) : a0_q;
    ub    = (d_sgn && b0_q[31]) ? (32'd0 - b0_q) : b0_q;
    dctl.want_rem    = d_rem;
    dctl.neg_q       = d_sgn && (a0_q[31] != b0_q[31]);
    dctl.neg_r       = d_sgn && a0_q[31];
    dctl.special     = (b0_q == 32'd0);
    dctl.special_val = d_rem ? a0_q : 32'hFFFF_FFFF;
  end

  logic        div_v;
  logic [31:0] div_res;
  rvalu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v0_q),
    .dividend_i (ua),
    .divisor_i  (ub),
    .ctl_i      (dctl),
    .valid_o    (div_v),
    .result_o   (div_res)
  );

  // Delay line for non-divide results: hold simple results two stages,
  // then join multiply output at stage 2, and carry on to match divider.
  logic [31:0] s1_q, s2_q;
  logic [1:0]  k1_q, k2_q;
  always_ff @(posedge clk_i) begin
    s1_q <= simple_d;
    k1_q <= is_div ? KIND_DIV : (is_mul ? KIND_MUL : KIND_SIMPLE);
    s2_q <= s1_q;
    k2_q <= k1_q;
  end
  logic [31:0] mix_d;
  assign mix_d = (k2_q == KIND_MUL) ? mul_res : s2_q;
  logic [31:0] dl_q [3:DLY];
  logic [1:0]  dk_q [3:DLY];
  for (genvar i = 3; i <= DLY; i++) begin : g_dly
    if (i == 3) begin : g_head
      always_ff @(posedge clk_i) begin
        dl_q[i] <= mix_d;
        dk_q[i] <= k2_q;
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        dl_q[i] <= dl_q[i-1];
        dk_q[i] <= dk_q[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= div_v;
    end
  end
  always_ff @(posedge clk_i) begin
    alu_result_o <= (dk_q[DLY] == KIND_DIV) ? div_res : dl_q[DLY];
  end

`ifndef SYNTH
  // Every accepted word raises done_o in step with a shift register of accepts.
  logic [DLY+1:0] trk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= '0;
    end else begin
      trk_q <= {trk_q[DLY:0], accept};
    end
  end
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == trk_q[DLY+1]) else $error("result strobe out of step with issue");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("pipeline stalled");
`endif

endmodule
`default_nettype wire
